// ----- hw/rtl/gbrm_pkg.sv -----
`timescale 1ns / 1ps
package gbrm_pkg;

  localparam int ROWS_DEF      = 40;
  localparam int COLS_DEF      = 60;
  localparam int MAX_STEPS_DEF = 4096;

  // Quotient bits delivered by the divider
  localparam int QB = 18;

  localparam logic [15:0] STEP_Q16  = 16'd6554;
  localparam logic [15:0] SLOPE_Q16 = 16'd13107;

  // Configuration register indexes
  localparam logic [2:0] CFG_HOLE_X      = 3'd0;
  localparam logic [2:0] CFG_HOLE_Y      = 3'd1;
  localparam logic [2:0] CFG_HOLE_Z      = 3'd2;
  localparam logic [2:0] CFG_HOLE_RADIUS = 3'd3;
  localparam logic [2:0] CFG_RING_INNER  = 3'd4;
  localparam logic [2:0] CFG_RING_OUTER  = 3'd5;
  localparam logic [2:0] CFG_RING_THICK  = 3'd6;
  localparam logic [2:0] CFG_GRAVITY     = 3'd7;

  // Pixel classes
  localparam logic [1:0] CLS_HOLE    = 2'd0;
  localparam logic [1:0] CLS_RING    = 2'd1;
  localparam logic [1:0] CLS_ESCAPED = 2'd2;
  localparam logic [1:0] CLS_LIMIT   = 2'd3;

  typedef enum logic [5:0] {
    U_NOP, U_LOAD, U_MUL_RR, U_SET_RR, U_MUL_IR, U_SET_IR, U_MUL_ER, U_SET_ER,
    U_MUL_RXX, U_ACC_LD, U_MUL_RYY, U_ACC_ADD, U_MUL_RZZ, U_SET_D2, U_BR_D2Z,
    U_SQRT_D2, U_DIV_FORCE, U_DIV_RX, U_MUL_QF, U_UPD_DX, U_DIV_RY, U_UPD_DY,
    U_DIV_RZ, U_UPD_DZ, U_MUL_DXX, U_MUL_DYY, U_MUL_DZZ, U_SQRT_M, U_BR_MZ,
    U_DIV_DX, U_NRM_DX, U_DIV_DY, U_NRM_DY, U_DIV_DZ, U_NRM_DZ, U_MUL_SX,
    U_ADV_X, U_MUL_SY, U_ADV_Y, U_MUL_SZ, U_ADV_Z, U_MUL_EXX, U_MUL_EZZ,
    U_SET_SXZ, U_MUL_EYY, U_MUL_TILT, U_CLASSIFY, U_BR_END
  } uop_t;

  // Branch targets of the microprogram
  localparam logic [5:0] PC_LOOP = 6'd7;
  localparam logic [5:0] PC_NORM = 6'd26;
  localparam logic [5:0] PC_ADV  = 6'd40;

  typedef struct packed {
    uop_t op;
    logic take_in;
    logic out_load;
  } gbrm_cmd_t;

  typedef struct packed {
    logic d2_zero;
    logic mag_zero;
    logic hit;
    logic unit_done;
  } gbrm_stat_t;

  function automatic uop_t uop_at(input logic [5:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = U_LOAD;
      6'd1:  u = U_MUL_RR;
      6'd2:  u = U_SET_RR;
      6'd3:  u = U_MUL_IR;
      6'd4:  u = U_SET_IR;
      6'd5:  u = U_MUL_ER;
      6'd6:  u = U_SET_ER;
      6'd7:  u = U_MUL_RXX;
      6'd8:  u = U_ACC_LD;
      6'd9:  u = U_MUL_RYY;
      6'd10: u = U_ACC_ADD;
      6'd11: u = U_MUL_RZZ;
      6'd12: u = U_ACC_ADD;
      6'd13: u = U_SET_D2;
      6'd14: u = U_BR_D2Z;
      6'd15: u = U_SQRT_D2;
      6'd16: u = U_DIV_FORCE;
      6'd17: u = U_DIV_RX;
      6'd18: u = U_MUL_QF;
      6'd19: u = U_UPD_DX;
      6'd20: u = U_DIV_RY;
      6'd21: u = U_MUL_QF;
      6'd22: u = U_UPD_DY;
      6'd23: u = U_DIV_RZ;
      6'd24: u = U_MUL_QF;
      6'd25: u = U_UPD_DZ;
      6'd26: u = U_MUL_DXX;
      6'd27: u = U_ACC_LD;
      6'd28: u = U_MUL_DYY;
      6'd29: u = U_ACC_ADD;
      6'd30: u = U_MUL_DZZ;
      6'd31: u = U_ACC_ADD;
      6'd32: u = U_SQRT_M;
      6'd33: u = U_BR_MZ;
      6'd34: u = U_DIV_DX;
      6'd35: u = U_NRM_DX;
      6'd36: u = U_DIV_DY;
      6'd37: u = U_NRM_DY;
      6'd38: u = U_DIV_DZ;
      6'd39: u = U_NRM_DZ;
      6'd40: u = U_MUL_SX;
      6'd41: u = U_ADV_X;
      6'd42: u = U_MUL_SY;
      6'd43: u = U_ADV_Y;
      6'd44: u = U_MUL_SZ;
      6'd45: u = U_ADV_Z;
      6'd46: u = U_MUL_EXX;
      6'd47: u = U_ACC_LD;
      6'd48: u = U_MUL_EZZ;
      6'd49: u = U_ACC_ADD;
      6'd50: u = U_SET_SXZ;
      6'd51: u = U_MUL_EYY;
      6'd52: u = U_ACC_ADD;
      6'd53: u = U_MUL_TILT;
      6'd54: u = U_CLASSIFY;
      6'd55: u = U_BR_END;
      default: u = U_NOP;
    endcase
    return u;
  endfunction

  // Ops that launch the divider or the root unit and wait for it
  function automatic logic uop_is_unit(input uop_t u);
    return (u == U_SQRT_D2) || (u == U_SQRT_M) || (u == U_DIV_FORCE) ||
           (u == U_DIV_RX) || (u == U_DIV_RY) || (u == U_DIV_RZ) ||
           (u == U_DIV_DX) || (u == U_DIV_DY) || (u == U_DIV_DZ);
  endfunction

  // Drop 16 fraction bits, rounding toward zero
  function automatic logic signed [35:0] trunc16(input logic signed [51:0] p);
    logic signed [35:0] s;
    s = p[51:16];
    if (p[51] && (p[15:0] != 16'd0)) s = s + 36'sd1;
    return s;
  endfunction

  function automatic logic signed [17:0] sat_dir(input logic signed [19:0] v);
    logic signed [17:0] s;
    if (v > 20'sd131071) s = 18'sd131071;
    else if (v < -20'sd131072) s = -18'sd131072;
    else s = v[17:0];
    return s;
  endfunction

  function automatic logic signed [23:0] sat_pos(input logic signed [25:0] v);
    logic signed [23:0] s;
    if (v > 26'sd8388607) s = 24'sd8388607;
    else if (v < -26'sd8388608) s = -24'sd8388608;
    else s = v[23:0];
    return s;
  endfunction

endpackage

// ----- hw/rtl/gbrm_div.sv -----
`timescale 1ns / 1ps
module gbrm_div
  import gbrm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [47:0]   num,
  input  logic [52:0]   den,
  output logic          done,
  output logic [QB-1:0] quot,
  output logic          ovf
);

  logic [47:0]   rem_r, rem_nxt;
  logic [70:0]   dsh_r, dsh_nxt;
  logic [QB-1:0] q_r, q_nxt;
  logic          ovf_r, ovf_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // Restoring division, one quotient bit a cycle
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {1'b0, den, 17'd0};
      q_nxt    = '0;
      ovf_nxt  = {23'd0, num} >= {den, 18'd0};
      cnt_nxt  = 5'(QB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({23'd0, rem_r} >= dsh_r) begin
        rem_nxt = rem_r - dsh_r[47:0];
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign ovf  = ovf_r;

endmodule

// ----- hw/rtl/gbrm_sqrt.sv -----
`timescale 1ns / 1ps
module gbrm_sqrt
  import gbrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [51:0] val,
  output logic        done,
  output logic [25:0] root
);

  logic [51:0] v_r, v_nxt;
  logic [51:0] r_r, r_nxt;
  logic [51:0] b_r, b_nxt;
  logic [51:0] t;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // Digit-by-digit integer root, one result bit a cycle
  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    t        = r_r + b_r;
    if (start) begin
      v_nxt    = val;
      r_nxt    = '0;
      b_nxt    = 52'd1 << 50;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_nxt = v_r - t;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r == 52'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r <= v_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r[25:0];

endmodule

// ----- hw/rtl/gbrm_dp.sv -----
`timescale 1ns / 1ps
module gbrm_dp
  import gbrm_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gbrm_cmd_t   cmd,
  output gbrm_stat_t  stat,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_column,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic [1:0]  out_pixel_class,
  output logic [5:0]  out_row,
  output logic [5:0]  out_column
);

  localparam logic signed [7:0]  HALF_R = 8'(ROWS / 2);
  localparam logic signed [7:0]  HALF_C = 8'(COLS / 2);
  localparam logic signed [25:0] XLIM   = 26'((ROWS / 2) * 65536);
  localparam logic signed [25:0] ZLIM   = 26'((COLS / 2) * 65536);

  // Configuration registers
  logic signed [5:0] hole_x_r, hole_y_r, hole_z_r;
  logic [12:0]       hole_radius_r, ring_inner_r, ring_outer_r, ring_thick_r;
  logic [15:0]       gravity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_x_r      <= '0;
      hole_y_r      <= '0;
      hole_z_r      <= '0;
      hole_radius_r <= 13'd1280;
      ring_inner_r  <= 13'd2048;
      ring_outer_r  <= 13'd5120;
      ring_thick_r  <= 13'd128;
      gravity_r     <= 16'd19661;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLE_X:      hole_x_r      <= cfg_wdata[5:0];
        CFG_HOLE_Y:      hole_y_r      <= cfg_wdata[5:0];
        CFG_HOLE_Z:      hole_z_r      <= cfg_wdata[5:0];
        CFG_HOLE_RADIUS: hole_radius_r <= cfg_wdata[12:0];
        CFG_RING_INNER:  ring_inner_r  <= cfg_wdata[12:0];
        CFG_RING_OUTER:  ring_outer_r  <= cfg_wdata[12:0];
        CFG_RING_THICK:  ring_thick_r  <= cfg_wdata[12:0];
        CFG_GRAVITY:     gravity_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ray state and scratch registers
  logic [5:0]         row_r, col_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic signed [17:0] dx_r, dy_r, dz_r;
  logic signed [51:0] prod_r;
  logic [51:0]        acc_r, d2_r, sxz_r, rr_r, ir2_r, er2_r;
  logic [25:0]        dist_r, mag_r;
  logic [16:0]        force_r;
  logic signed [18:0] q_r;
  logic [1:0]         cls_r;
  logic               hit_r;
  logic               neg_r;
  uop_t               dst_r;
  logic [1:0]         ocls_r;
  logic [5:0]         orow_r, ocol_r;

  // Offsets to the hole
  logic signed [25:0] hx, hy, hz, pxe, pye, pze;
  logic signed [25:0] rx, ry, rz, ex, ey, ez;

  assign hx  = {{4{hole_x_r[5]}}, hole_x_r, 16'd0};
  assign hy  = {{4{hole_y_r[5]}}, hole_y_r, 16'd0};
  assign hz  = {{4{hole_z_r[5]}}, hole_z_r, 16'd0};
  assign pxe = {{2{px_r[23]}}, px_r};
  assign pye = {{2{py_r[23]}}, py_r};
  assign pze = {{2{pz_r[23]}}, pz_r};
  assign rx  = hx - pxe;
  assign ry  = hy - pye;
  assign rz  = hz - pze;
  assign ex  = pxe - hx;
  assign ey  = pye - hy;
  assign ez  = pze - hz;

  // Shared multiplier operand selection
  logic signed [25:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      U_MUL_RR:   begin ma = {13'd0, hole_radius_r}; mb = ma; end
      U_MUL_IR:   begin ma = {13'd0, ring_inner_r};  mb = ma; end
      U_MUL_ER:   begin ma = {13'd0, ring_outer_r};  mb = ma; end
      U_MUL_RXX:  begin ma = rx; mb = rx; end
      U_MUL_RYY:  begin ma = ry; mb = ry; end
      U_MUL_RZZ:  begin ma = rz; mb = rz; end
      U_MUL_QF:   begin ma = {{7{q_r[18]}}, q_r}; mb = {9'd0, force_r}; end
      U_MUL_DXX:  begin ma = {{8{dx_r[17]}}, dx_r}; mb = ma; end
      U_MUL_DYY:  begin ma = {{8{dy_r[17]}}, dy_r}; mb = ma; end
      U_MUL_DZZ:  begin ma = {{8{dz_r[17]}}, dz_r}; mb = ma; end
      U_MUL_SX:   begin ma = {{8{dx_r[17]}}, dx_r}; mb = {10'd0, STEP_Q16}; end
      U_MUL_SY:   begin ma = {{8{dy_r[17]}}, dy_r}; mb = {10'd0, STEP_Q16}; end
      U_MUL_SZ:   begin ma = {{8{dz_r[17]}}, dz_r}; mb = {10'd0, STEP_Q16}; end
      U_MUL_EXX:  begin ma = ex; mb = ex; end
      U_MUL_EYY:  begin ma = ey; mb = ey; end
      U_MUL_EZZ:  begin ma = ez; mb = ez; end
      U_MUL_TILT: begin ma = pxe; mb = {10'd0, SLOPE_Q16}; end
      default: ;
    endcase
  end

  // Divider and root unit operands
  logic [25:0] rabs;
  logic [18:0] dabs;
  logic [47:0] dnum;
  logic [52:0] dden;
  logic        dneg, dstart, sstart;
  logic [51:0] sval;

  always_comb begin
    rabs   = '0;
    dabs   = '0;
    dnum   = '0;
    dden   = {27'd0, dist_r};
    dneg   = 1'b0;
    dstart = 1'b1;
    unique case (cmd.op)
      U_DIV_FORCE: begin
        dnum = {gravity_r, 32'd0};
        dden = {1'b0, d2_r} + (53'd1 << 32);
      end
      U_DIV_RX: begin
        rabs = rx[25] ? -rx : rx; dneg = rx[25]; dnum = {7'd0, rabs[24:0], 16'd0};
      end
      U_DIV_RY: begin
        rabs = ry[25] ? -ry : ry; dneg = ry[25]; dnum = {7'd0, rabs[24:0], 16'd0};
      end
      U_DIV_RZ: begin
        rabs = rz[25] ? -rz : rz; dneg = rz[25]; dnum = {7'd0, rabs[24:0], 16'd0};
      end
      U_DIV_DX: begin
        dabs = dx_r[17] ? -{dx_r[17], dx_r} : {dx_r[17], dx_r};
        dneg = dx_r[17]; dnum = {14'd0, dabs[17:0], 16'd0}; dden = {27'd0, mag_r};
      end
      U_DIV_DY: begin
        dabs = dy_r[17] ? -{dy_r[17], dy_r} : {dy_r[17], dy_r};
        dneg = dy_r[17]; dnum = {14'd0, dabs[17:0], 16'd0}; dden = {27'd0, mag_r};
      end
      U_DIV_DZ: begin
        dabs = dz_r[17] ? -{dz_r[17], dz_r} : {dz_r[17], dz_r};
        dneg = dz_r[17]; dnum = {14'd0, dabs[17:0], 16'd0}; dden = {27'd0, mag_r};
      end
      default: dstart = 1'b0;
    endcase
  end

  assign sstart = (cmd.op == U_SQRT_D2) || (cmd.op == U_SQRT_M);
  assign sval   = (cmd.op == U_SQRT_D2) ? d2_r : acc_r;

  logic          ddone, dovf, sdone;
  logic [QB-1:0] dquot;
  logic [25:0]   sroot;

  gbrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quot  (dquot),
    .ovf   (dovf)
  );

  gbrm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sstart),
    .val   (sval),
    .done  (sdone),
    .root  (sroot)
  );

  // Rescaled product and the updates that use it
  logic signed [35:0] tr;
  logic signed [19:0] nq;
  logic signed [17:0] nrm;
  logic signed [18:0] qsig;
  logic signed [7:0]  yoff, zoff;
  logic signed [25:0] tilt, half_t, ylo, yhi;
  logic               in_hole, in_ring, in_box_out;

  assign tr   = trunc16(prod_r);
  assign nq   = dovf ? (neg_r ? -20'sd131072 : 20'sd131071)
                     : (neg_r ? -$signed({2'b0, dquot}) : $signed({2'b0, dquot}));
  assign nrm  = sat_dir(nq);
  assign qsig = neg_r ? -$signed({1'b0, dquot}) : $signed({1'b0, dquot});
  assign yoff = $signed({2'b0, row_r}) - HALF_R;
  assign zoff = $signed({2'b0, col_r}) - HALF_C;

  assign tilt   = tr[25:0];
  assign half_t = {6'd0, ring_thick_r, 7'd0};
  assign yhi    = half_t - tilt;
  assign ylo    = -half_t - tilt;

  // Hit tests, a later one overriding an earlier one
  assign in_hole    = acc_r <= rr_r;
  assign in_ring    = (sxz_r <= er2_r) && (sxz_r >= ir2_r) && (pye <= yhi) && (pye >= ylo);
  assign in_box_out = (pxe >= XLIM) || (pxe <= -XLIM) || (pye >= XLIM) ||
                      (pye <= -XLIM) || (pze >= ZLIM) || (pze <= -ZLIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= CLS_LIMIT;
      hit_r <= 1'b0;
    end else begin
      if (cmd.op == U_LOAD) begin
        cls_r <= CLS_LIMIT;
        hit_r <= 1'b0;
      end else if (cmd.op == U_CLASSIFY) begin
        hit_r <= in_hole || in_ring || in_box_out;
        if (in_box_out)   cls_r <= CLS_ESCAPED;
        else if (in_ring) cls_r <= CLS_RING;
        else if (in_hole) cls_r <= CLS_HOLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (cmd.take_in) begin
      row_r <= in_row;
      col_r <= in_column;
    end
    if (dstart || sstart) begin
      dst_r <= cmd.op;
      neg_r <= dneg;
    end
    if (cmd.out_load) begin
      ocls_r <= cls_r;
      orow_r <= row_r;
      ocol_r <= col_r;
    end
    // Capture unit results
    if (sdone) begin
      if (dst_r == U_SQRT_D2) dist_r <= sroot;
      else                    mag_r  <= sroot;
    end
    if (ddone) begin
      unique case (dst_r)
        U_DIV_FORCE: force_r <= dquot[16:0];
        U_DIV_RX, U_DIV_RY, U_DIV_RZ: q_r <= qsig;
        U_DIV_DX: dx_r <= nrm;
        U_DIV_DY: dy_r <= nrm;
        U_DIV_DZ: dz_r <= nrm;
        default: ;
      endcase
    end
    unique case (cmd.op)
      U_LOAD: begin
        px_r <= -24'sd1310720;
        py_r <= {yoff, 16'd0};
        pz_r <= {zoff, 16'd0};
        dx_r <= 18'sd65536;
        dy_r <= '0;
        dz_r <= '0;
      end
      U_SET_RR:  rr_r  <= {10'd0, prod_r[25:16], 32'd0};
      U_SET_IR:  ir2_r <= {10'd0, prod_r[25:0], 16'd0};
      U_SET_ER:  er2_r <= {10'd0, prod_r[25:0], 16'd0};
      U_ACC_LD:  acc_r <= prod_r;
      U_ACC_ADD: acc_r <= acc_r + prod_r;
      U_SET_D2:  d2_r  <= acc_r;
      U_SET_SXZ: sxz_r <= acc_r;
      U_UPD_DX:  dx_r  <= sat_dir({{2{dx_r[17]}}, dx_r} + tr[19:0]);
      U_UPD_DY:  dy_r  <= sat_dir({{2{dy_r[17]}}, dy_r} + tr[19:0]);
      U_UPD_DZ:  dz_r  <= sat_dir({{2{dz_r[17]}}, dz_r} + tr[19:0]);
      U_ADV_X:   px_r  <= sat_pos(pxe + tr[25:0]);
      U_ADV_Y:   py_r  <= sat_pos(pye + tr[25:0]);
      U_ADV_Z:   pz_r  <= sat_pos(pze + tr[25:0]);
      default: ;
    endcase
  end

  assign stat.d2_zero   = d2_r == 52'd0;
  assign stat.mag_zero  = mag_r == 26'd0;
  assign stat.hit       = hit_r;
  assign stat.unit_done = ddone || sdone;

  assign out_pixel_class = ocls_r;
  assign out_row         = orow_r;
  assign out_column      = ocol_r;

endmodule

// ----- hw/rtl/gbrm_ctrl.sv -----
`timescale 1ns / 1ps
module gbrm_ctrl
  import gbrm_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output gbrm_cmd_t  cmd,
  input  gbrm_stat_t stat
);

  localparam int SW = $clog2(MAX_STEPS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [5:0]    pc_r, pc_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          ov_r, ov_nxt;
  uop_t          op;
  logic          take, load;

  assign op   = uop_at(pc_r);
  assign take = (state_r == S_IDLE) && in_valid;
  assign load = (state_r == S_DONE) && (!ov_r || !out_stall);

  // Sequence the microprogram
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
          pc_nxt    = '0;
          step_nxt  = '0;
        end
      end
      S_EXEC: begin
        pc_nxt = pc_r + 6'd1;
        if (op == U_BR_D2Z && stat.d2_zero) begin
          pc_nxt = PC_NORM;
        end else if (op == U_BR_MZ && stat.mag_zero) begin
          pc_nxt = PC_ADV;
        end else if (op == U_BR_END) begin
          if (stat.hit || step_r == SW'(MAX_STEPS - 1)) begin
            state_nxt = S_DONE;
          end else begin
            step_nxt = step_r + 1'b1;
            pc_nxt   = PC_LOOP;
          end
        end else if (uop_is_unit(op)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.unit_done) state_nxt = S_EXEC;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      step_r  <= step_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall     = state_r != S_IDLE;
  assign out_valid    = ov_r;
  assign cmd.op       = (state_r == S_EXEC) ? op : U_NOP;
  assign cmd.take_in  = take;
  assign cmd.out_load = load;

endmodule

// ----- hw/rtl/gravity_bent_ray_marcher.sv -----
`timescale 1ns / 1ps
// Channel  | handshake            | payload
// in       | in_valid / in_stall  | in_row, in_column
// out      | out_valid / out_stall| out_pixel_class, out_row, out_column
// cfg      | cfg_we               | cfg_index, cfg_wdata
//
// With the pull applied, one march step makes nine divider or root runs on the
// shared bit-serial units, besides the other microcode ops. A ray adds setup
// and hand-off and takes up to MAX_STEPS steps.
// Reset is synchronous and active low; configuration returns to its defaults.
// One ray is marched at a time; the next pixel is taken as soon as the result
// sits in the output register, and a stalled result holds there.
module gravity_bent_ray_marcher
  import gbrm_pkg::*;
#(
  parameter int ROWS      = ROWS_DEF,
  parameter int COLS      = COLS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_pixel_class,
  output logic [5:0]  out_row,
  output logic [5:0]  out_column,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  gbrm_cmd_t  cmd;
  gbrm_stat_t stat;

  gbrm_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  gbrm_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_row          (in_row),
    .in_column       (in_column),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_pixel_class (out_pixel_class),
    .out_row         (out_row),
    .out_column      (out_column)
  );

endmodule

// ----- hw/rtl/gbrm_checker.sv -----
`timescale 1ns / 1ps
module gbrm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_pixel_class,
  input logic [5:0] out_row,
  input logic [5:0] out_column
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_class) &&
    $stable(out_row) && $stable(out_column))
    else $error("stalled result changed");

  // Busy once a pixel is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second pixel taken while marching");

  // No result straight after a pixel is taken
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared without marching");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gravity_bent_ray_marcher gbrm_checker u_gbrm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_class (out_pixel_class),
  .out_row         (out_row),
  .out_column      (out_column)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top
  import gbrm_pkg::*;
;

  typedef struct {
    logic [1:0] pclass;
    logic [5:0] row;
    logic [5:0] column;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  in_row;
  logic [5:0]  in_column;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_pixel_class;
  logic [5:0]  out_row;
  logic [5:0]  out_column;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Shadow copy of the configuration
  longint hole_xq, hole_yq, hole_zq;
  longint hole_rad, ring_in, ring_out, ring_thick, pull_k;

  pixel_result_t pending_pixels[$];
  int errors;
  int burst_left;
  int unsigned stall_tick;
  logic [31:0] stall_mask;

  gravity_bent_ray_marcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_class(out_pixel_class),
    .out_row(out_row), .out_column(out_column),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // March one ray in fixed point and return its class
  function automatic logic [1:0] march_class(input logic [5:0] row, input logic [5:0] column);
    longint hx, hy, hz, px, py, pz, dx, dy, dz;
    longint rx, ry, rz, d2, dist_q, force_q, m2, mag, ex, ey, ez, syz, sxz, tilt;
    longint rr, ir2, er2, half_t, xlim, ylim, zlim;
    logic [1:0] cls;
    logic hit;
    hx = hole_xq * 65536;
    hy = hole_yq * 65536;
    hz = hole_zq * 65536;
    px = -20 * 65536;
    py = (longint'(row) - ROWS_DEF / 2) * 65536;
    pz = (longint'(column) - COLS_DEF / 2) * 65536;
    dx = 65536;
    dy = 0;
    dz = 0;
    rr = ((hole_rad * hole_rad) >> 16) << 32;
    ir2 = (ring_in * ring_in) << 16;
    er2 = (ring_out * ring_out) << 16;
    half_t = ring_thick << 7;
    xlim = (ROWS_DEF / 2) * 65536;
    ylim = xlim;
    zlim = (COLS_DEF / 2) * 65536;
    cls = CLS_LIMIT;
    for (int n = 0; n < MAX_STEPS_DEF; n++) begin
      rx = hx - px;
      ry = hy - py;
      rz = hz - pz;
      d2 = rx * rx + ry * ry + rz * rz;
      hit = 1'b0;
      // Pull toward the hole, skipped at its exact centre
      if (d2 != 0) begin
        dist_q = root_floor(d2);
        force_q = (pull_k << 32) / (d2 + (64'sd1 << 32));
        dx = clamp(dx + (rx * 65536 / dist_q) * force_q / 65536, -131072, 131071);
        dy = clamp(dy + (ry * 65536 / dist_q) * force_q / 65536, -131072, 131071);
        dz = clamp(dz + (rz * 65536 / dist_q) * force_q / 65536, -131072, 131071);
      end
      m2 = dx * dx + dy * dy + dz * dz;
      mag = root_floor(m2);
      if (mag != 0) begin
        dx = clamp(dx * 65536 / mag, -131072, 131071);
        dy = clamp(dy * 65536 / mag, -131072, 131071);
        dz = clamp(dz * 65536 / mag, -131072, 131071);
      end
      px = clamp(px + dx * longint'(STEP_Q16) / 65536, -8388608, 8388607);
      py = clamp(py + dy * longint'(STEP_Q16) / 65536, -8388608, 8388607);
      pz = clamp(pz + dz * longint'(STEP_Q16) / 65536, -8388608, 8388607);
      ex = px - hx;
      ey = py - hy;
      ez = pz - hz;
      syz = ex * ex + ey * ey + ez * ez;
      if (syz <= rr) begin
        cls = CLS_HOLE;
        hit = 1'b1;
      end
      sxz = ex * ex + ez * ez;
      tilt = px * longint'(SLOPE_Q16) / 65536;
      if (sxz <= er2 && sxz >= ir2 && py <= half_t - tilt && py >= -half_t - tilt) begin
        cls = CLS_RING;
        hit = 1'b1;
      end
      if (px >= xlim || px <= -xlim || py >= ylim || py <= -ylim ||
          pz >= zlim || pz <= -zlim) begin
        cls = CLS_ESCAPED;
        hit = 1'b1;
      end
      if (hit) break;
    end
    return cls;
  endfunction

  // Write one register while the block is idle
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HOLE_X:      hole_xq = longint'($signed(val[5:0]));
      CFG_HOLE_Y:      hole_yq = longint'($signed(val[5:0]));
      CFG_HOLE_Z:      hole_zq = longint'($signed(val[5:0]));
      CFG_HOLE_RADIUS: hole_rad = longint'(val[12:0]);
      CFG_RING_INNER:  ring_in = longint'(val[12:0]);
      CFG_RING_OUTER:  ring_out = longint'(val[12:0]);
      CFG_RING_THICK:  ring_thick = longint'(val[12:0]);
      CFG_GRAVITY:     pull_k = longint'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_all(input int x, input int y, input int z, input int rad,
                         input int rin, input int rout, input int thick, input int k);
    cfg_write(CFG_HOLE_X, 16'(x));
    cfg_write(CFG_HOLE_Y, 16'(y));
    cfg_write(CFG_HOLE_Z, 16'(z));
    cfg_write(CFG_HOLE_RADIUS, 16'(rad));
    cfg_write(CFG_RING_INNER, 16'(rin));
    cfg_write(CFG_RING_OUTER, 16'(rout));
    cfg_write(CFG_RING_THICK, 16'(thick));
    cfg_write(CFG_GRAVITY, 16'(k));
  endtask

  // Offer one pixel; valid stays high afterwards until a gap or a drain
  task automatic send_pixel(input logic [5:0] row, input logic [5:0] column);
    pixel_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_row <= row;
    in_column <= column;
    r.pclass = march_class(row, column);
    r.row = row;
    r.column = column;
    // Inputs only move at rising edges, so the falling edge sees settled stall
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_pixels.push_back(r);
  endtask

  // Hold off the sender until every transaction has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_default_pixels();
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd39, 6'd59);
    send_pixel(6'd20, 6'd30);
    send_pixel(6'd63, 6'd0);
    send_pixel(6'd0, 6'd63);
    send_pixel(6'd21, 6'd28);
    send_pixel(6'd18, 6'd33);
    drain_results();
  endtask

  task automatic test_hole_centre();
    // Ray starts exactly on the hole centre
    cfg_all(-20, 0, 0, 256, 2048, 5120, 128, 19661);
    send_pixel(6'd20, 6'd30);
    send_pixel(6'd21, 6'd30);
    drain_results();
    // Hole right behind the start, strongest pull
    cfg_all(-21, 0, 0, 0, 0, 0, 0, 65535);
    send_pixel(6'd20, 6'd30);
    drain_results();
  endtask

  task automatic test_register_extremes();
    cfg_all(31, -32, 31, 8191, 0, 8191, 8191, 0);
    send_pixel(6'd20, 6'd30);
    send_pixel(6'd42, 6'd21);
    drain_results();
    cfg_all(-32, 31, -32, 0, 8191, 0, 0, 65535);
    send_pixel(6'd10, 6'd50);
    send_pixel(6'd30, 6'd5);
    drain_results();
    cfg_all(0, 0, 0, 0, 0, 8191, 8191, 0);
    send_pixel(6'd20, 6'd30);
    send_pixel(6'd5, 6'd45);
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        cfg_all(0, 0, 0, 1280, 2048, 5120, 128, 19661);
      end else begin
        cfg_all($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                $urandom_range(0, 16) - 8, $urandom_range(0, 2048),
                $urandom_range(0, 3072), $urandom_range(1024, 8191),
                $urandom_range(0, 8191), $urandom);
      end
      for (int i = 0; i < 17; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_pixel(6'($urandom), 6'($urandom));
        else
          send_pixel(6'($urandom_range(0, ROWS_DEF - 1)), 6'($urandom_range(0, COLS_DEF - 1)));
      end
      drain_results();
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick <= 0;
      stall_mask <= 32'd0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd0)
        stall_mask <= ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      out_stall <= stall_mask[stall_tick[4:0]];
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(negedge clk) begin
    pixel_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual class %0d row %0d column %0d",
                 $time, out_pixel_class, out_row, out_column);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_pixel_class !== e.pclass) begin
          $display("%0t: class mismatch: expected %0d, actual %0d", $time, e.pclass,
                   out_pixel_class);
          errors++;
        end
        if (out_row !== e.row) begin
          $display("%0t: row mismatch: expected %0d, actual %0d", $time, e.row, out_row);
          errors++;
        end
        if (out_column !== e.column) begin
          $display("%0t: column mismatch: expected %0d, actual %0d", $time, e.column,
                   out_column);
          errors++;
        end
      end
    end
  end

  initial begin
    #(1.0e10);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_row <= 6'd0;
    in_column <= 6'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HOLE_X;
    cfg_wdata <= 16'd0;
    errors = 0;
    burst_left = 0;
    hole_xq = 0;
    hole_yq = 0;
    hole_zq = 0;
    hole_rad = 1280;
    ring_in = 2048;
    ring_out = 5120;
    ring_thick = 128;
    pull_k = 19661;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_pixels();
    test_hole_centre();
    test_register_extremes();
    test_random_phases();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
